// File: design/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types and constants for the custom-alphabet base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int CharW      = 8;
  localparam int SextW      = 6;
  localparam int AlphaSize  = 64;
  localparam int AlphaWords = 8;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 64;
  localparam int QDepth     = 2;
  localparam int QPtrW      = $clog2(QDepth);
  localparam int QCntW      = $clog2(QDepth + 1);

  localparam logic [CharW-1:0] ChSpace   = 8'h20;
  localparam logic [CharW-1:0] ChNewline = 8'h0A;
  localparam logic [CharW-1:0] ChPad     = 8'h3D;

  typedef logic [SextW-1:0] sextet_t;

  // One decoded group: up to three bytes and how many of them are valid (1..3)
  typedef struct packed {
    logic [CharW-1:0] b2;
    logic [CharW-1:0] b1;
    logic [CharW-1:0] b0;
    logic [1:0]       count;
  } group_t;

  typedef struct packed {
    logic   push;
    group_t grp;
  } qwrite_t;

  typedef struct packed {
    logic   valid;
    group_t grp;
  } qread_t;

endpackage

// File: design/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, drops whitespace, maps each kept character through the
// alphabet and assembles groups of four sextets into byte groups.
// ----------------------------------------------------------------------------
module b64d_front
  import b64d_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                in_valid,
  input  logic [CharW-1:0]    in_char,
  input  logic                in_end,
  output logic                in_ready,
  input  logic                q_full,
  output qwrite_t             q_wr
);

  logic [CfgDataW-1:0] alphabet [AlphaWords];
  sextet_t             store [3];
  logic [1:0]          group_count;
  logic [2:0]          pad_count;

  logic       accept;
  logic       skip;
  sextet_t    sext;
  logic [2:0] pad_new;
  logic [2:0] pad_eff;
  logic       emit;
  sextet_t    s2;
  sextet_t    s3;
  sextet_t    s2z;
  sextet_t    s3z;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign skip     = !in_end && (in_char == ChSpace || in_char == ChNewline);

  // lowest matching index wins; no match gives zero
  always_comb begin
    sext = '0;
    for (int k = AlphaSize - 1; k >= 0; k--) begin
      if (alphabet[k / 8][8 * (k % 8) +: 8] == in_char) begin
        sext = SextW'(k);
      end
    end
  end

  always_comb begin
    pad_new = pad_count;
    if (in_char == ChPad && pad_count != 3'd7) begin
      pad_new = pad_count + 3'd1;
    end
  end

  always_comb begin
    if (in_end) begin
      emit    = (group_count != 2'd0);
      pad_eff = pad_count;
      s2      = store[2];
      s3      = '0;
    end else begin
      emit    = (group_count == 2'd3);
      pad_eff = pad_new;
      s2      = store[2];
      s3      = sext;
    end
    s3z = (pad_eff >= 3'd1) ? '0 : s3;
    s2z = (pad_eff == 3'd2) ? '0 : s2;
    q_wr.grp.b0    = {store[0], store[1][5:4]};
    q_wr.grp.b1    = {store[1][3:0], s2z[5:2]};
    q_wr.grp.b2    = {s2z[1:0], s3z};
    q_wr.grp.count = 2'(3'd3 - pad_eff);
    q_wr.push      = accept && !skip && emit && (pad_eff < 3'd3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AlphaWords; i++) alphabet[i] <= '0;
    end else if (cfg_we) begin
      alphabet[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_count <= '0;
      pad_count   <= '0;
      for (int i = 0; i < 3; i++) store[i] <= '0;
    end else if (accept && !skip) begin
      if (emit) begin
        group_count <= '0;
        pad_count   <= '0;
        for (int i = 0; i < 3; i++) store[i] <= '0;
      end else if (!in_end) begin
        store[group_count] <= sext;
        group_count        <= group_count + 2'd1;
        pad_count          <= pad_new;
      end
    end
  end

endmodule

// File: design/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue
// Short queue of decoded groups between the front and the byte serialiser.
// ----------------------------------------------------------------------------
module b64d_queue
  import b64d_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  qwrite_t q_wr,
  output logic    q_full,
  input  logic    pop,
  output qread_t  q_rd
);

  group_t           slots [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;
  logic             do_pop;

  assign q_full     = (count == QCntW'(QDepth));
  assign q_rd.valid = (count != '0);
  assign q_rd.grp   = slots[rd_ptr];
  assign do_pop     = pop && q_rd.valid;

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      slots[wr_ptr] <= q_wr.grp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_wr.push) begin
        wr_ptr <= (wr_ptr == QPtrW'(QDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPtrW'(QDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (q_wr.push && !do_pop) begin
        count <= count + QCntW'(1);
      end else if (!q_wr.push && do_pop) begin
        count <= count - QCntW'(1);
      end
    end
  end

endmodule

// File: design/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// Takes decoded groups from the queue and sends their bytes one per item,
// marking the final byte of each group.
// ----------------------------------------------------------------------------
module b64d_back
  import b64d_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  qread_t           q_rd,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [CharW-1:0] out_data,
  output logic             out_last
);

  group_t     cur;
  logic       busy;
  logic [1:0] idx;
  logic       fire;

  assign out_valid = busy;
  assign out_last  = (idx == cur.count - 2'd1);
  assign fire      = busy && out_ready;
  assign pop       = q_rd.valid && (!busy || (fire && out_last));

  always_comb begin
    unique case (idx)
      2'd0:    out_data = cur.b0;
      2'd1:    out_data = cur.b1;
      default: out_data = cur.b2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_rd.grp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (pop) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (fire) begin
      if (out_last) begin
        busy <= 1'b0;
        idx  <= '0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule

// File: design/base64_decoder_custom_alphabet.sv
// ----------------------------------------------------------------------------
// base64_decoder_custom_alphabet
// Base64 decoder with a 64-entry alphabet loaded through a write port.
// ----------------------------------------------------------------------------
// The slave stream takes one character per cycle. Spaces and newlines are
// dropped; every other character is matched against all 64 alphabet bytes at
// once (lowest index wins, no match gives zero) and joins the current group.
// The fourth kept character closes a group, tlast on the slave side flushes a
// partial group with zero sextets and its character is not decoded. A closed
// group yields 3 minus the number of '=' seen in it (nothing for three or
// more) as bytes on the master stream, one per cycle while m_tready is high,
// tlast set on the last byte of the group. A two-entry group queue parts the
// character side from the byte side, so input keeps flowing at one item per
// cycle while bytes drain; input stalls only when both queue entries and the
// serialiser are occupied, e.g. after flushes that follow one another closely.
// The user must write alphabet words with cfg_we while idle (not enforced).
// Word i holds entries 8i..8i+7, entry 8i in the low byte.
// ----------------------------------------------------------------------------
module base64_decoder_custom_alphabet
  import b64d_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // configuration write port
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  // character stream
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [CharW-1:0]    s_tdata,   // [7:0] char_byte
  input  logic                s_tlast,   // end_of_input
  // decoded byte stream
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [CharW-1:0]    m_tdata,   // [7:0] data_byte
  output logic                m_tlast    // last_of_group
);

  qwrite_t q_wr;
  qread_t  q_rd;
  logic    q_full;
  logic    pop;

  // classify, look up and assemble groups
  b64d_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .in_char   (s_tdata),
    .in_end    (s_tlast),
    .in_ready  (s_tready),
    .q_full    (q_full),
    .q_wr      (q_wr)
  );

  // decoupling queue of finished groups
  b64d_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_wr   (q_wr),
    .q_full (q_full),
    .pop    (pop),
    .q_rd   (q_rd)
  );

  // byte serialiser
  b64d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_rd      (q_rd),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule
